[design/assert_macros.svh]
// Shared assertion macros. Both sample on the rising edge of clk and are
// switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mtl_pkg.sv]
package mtl_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int USER_BITS_DEF = 16;

    localparam logic [1:0] CMD_LOCK    = 2'd0;
    localparam logic [1:0] CMD_UNLOCK  = 2'd1;
    localparam logic [1:0] CMD_UPGRADE = 2'd2;

    localparam logic CFG_BRANCH = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    localparam logic [4:0] BRANCH_RST = 5'd2;
    localparam logic [8:0] COUNT_RST  = 9'd256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic scan_init;
        logic scan_step;
        logic do_lock;
        logic do_unlock;
        logic do_upgrade;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       in_range;
        logic       t_locked;
        logic       anc_hit;
        logic       desc_any;
        logic       mism;
        logic       owner_eq;
        logic       scan_last;
    } ctl_sts_t;

endpackage

[design/mary_tree_hierarchical_lock_unit.sv]
// Lock and upgrade requests pass decode, a sweep over the nodes, then a tail step.
// Unlocks add owner read and check; rejects end at decode; one request is in work at a time.
// The sweep over all nodes, one node per cycle with one owner memory read, sets the rate.
// Reset (rst_n low, asynchronous) clears every lock and sets branch factor 2 and 256 nodes.
// Any configuration write also releases every lock.
module mary_tree_hierarchical_lock_unit #(
    parameter int MAX_NODES = mtl_pkg::MAX_NODES_DEF,
    parameter int USER_BITS = mtl_pkg::USER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  node_index,
    input  logic [15:0] user_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        success,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    import mtl_pkg::*;

    ctl_cmd_t ctl;
    ctl_sts_t sts;

    // Configuration is accepted only while no request is in work, so a write can never
    // disturb a sweep that is under way.
    assign cfg_ready = !in_stall;

    // The controller sequences decode, the tree sweep and the state update; the
    // datapath holds the lock flags, owner memory and sweep bookkeeping.
    mtl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .success   (success),
        .ctl       (ctl),
        .sts       (sts)
    );

    mtl_datapath #(
        .MAX_NODES (MAX_NODES),
        .USER_BITS (USER_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .command    (command),
        .node_index (node_index),
        .user_id    (user_id),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

endmodule

[design/mtl_datapath.sv]
module mtl_datapath #(
    parameter int MAX_NODES = mtl_pkg::MAX_NODES_DEF,
    parameter int USER_BITS = mtl_pkg::USER_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mtl_pkg::ctl_cmd_t  ctl,
    output mtl_pkg::ctl_sts_t  sts,
    input  logic [1:0]         command,
    input  logic [7:0]         node_index,
    input  logic [15:0]        user_id,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data
);
    import mtl_pkg::*;

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW = (IW + 1 > 9) ? IW + 1 : 9;

    logic [1:0]           cmd_reg;
    logic [NW-1:0]        t_reg;
    logic [USER_BITS-1:0] user_reg;
    logic [4:0]           branch_reg;
    logic [8:0]           count_reg;
    logic [MAX_NODES-1:0] locked_reg;
    logic [MAX_NODES-1:0] sub_reg;
    logic [MAX_NODES-1:0] lp_reg;
    logic [NW-1:0]        j_reg;
    logic [IW-1:0]        p_reg;
    logic [4:0]           c_reg;
    logic                 anc_reg;
    logic                 desc_reg;
    logic                 mism_reg;
    logic                 chk_reg;
    logic [USER_BITS-1:0] owner_q_reg;
    logic [USER_BITS-1:0] owner_mem [MAX_NODES];

    logic [31:0]          user_w;
    logic [4:0]           m_eff;
    logic [NW-1:0]        count_w;
    logic [NW-1:0]        n_eff;
    logic [IW-1:0]        t_idx;
    logic [IW-1:0]        j_idx;
    logic [IW-1:0]        rd_addr;
    logic                 j_nz;
    logic                 is_t;
    logic                 par_sub;
    logic                 par_lp;
    logic                 lk_j;
    logic                 owner_ne;

    assign user_w  = 32'(user_id);
    assign m_eff   = (branch_reg == 5'd0) ? 5'd1 : ((branch_reg > 5'd16) ? 5'd16 : branch_reg);
    assign count_w = NW'(count_reg);
    assign n_eff   = (count_w > NW'(MAX_NODES)) ? NW'(MAX_NODES) : count_w;
    assign t_idx   = t_reg[IW-1:0];
    assign j_idx   = j_reg[IW-1:0];
    assign rd_addr = ctl.scan_step ? j_idx : t_idx;
    assign j_nz    = (j_reg != '0);
    assign is_t    = (j_reg == t_reg);
    assign par_sub = j_nz & sub_reg[p_reg];
    assign par_lp  = j_nz & lp_reg[p_reg];
    assign lk_j    = locked_reg[j_idx];
    assign owner_ne = (owner_q_reg != user_reg);

    assign sts.cmd       = cmd_reg;
    assign sts.in_range  = (t_reg < n_eff);
    assign sts.t_locked  = locked_reg[t_idx];
    assign sts.anc_hit   = anc_reg;
    assign sts.desc_any  = desc_reg;
    assign sts.mism      = mism_reg | (chk_reg & owner_ne);
    assign sts.owner_eq  = !owner_ne;
    assign sts.scan_last = (j_reg == n_eff - NW'(1));

    // Request payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cmd_reg  <= command;
            t_reg    <= NW'(node_index);
            user_reg <= user_w[USER_BITS-1:0];
        end
    end

    // Owner store: only read where the lock flag is set, so it needs no clearing.
    always_ff @(posedge clk)
    begin
        if (ctl.do_lock || ctl.do_upgrade)
        begin
            owner_mem[t_idx] <= user_reg;
        end
        owner_q_reg <= owner_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            branch_reg <= BRANCH_RST;
            count_reg  <= COUNT_RST;
            locked_reg <= '0;
            sub_reg    <= '0;
            lp_reg     <= '0;
            j_reg      <= '0;
            p_reg      <= '0;
            c_reg      <= 5'd1;
            anc_reg    <= 1'b0;
            desc_reg   <= 1'b0;
            mism_reg   <= 1'b0;
            chk_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BRANCH)
                begin
                    branch_reg <= cfg_data[4:0];
                end
                else
                begin
                    count_reg <= cfg_data;
                end
                locked_reg <= '0;
            end
            else if (ctl.do_lock)
            begin
                locked_reg[t_idx] <= 1'b1;
            end
            else if (ctl.do_unlock)
            begin
                locked_reg[t_idx] <= 1'b0;
            end
            else if (ctl.do_upgrade)
            begin
                locked_reg <= (locked_reg & ~sub_reg) | (MAX_NODES'(1) << t_idx);
            end

            if (ctl.scan_init)
            begin
                j_reg    <= '0;
                p_reg    <= '0;
                c_reg    <= 5'd1;
                anc_reg  <= 1'b0;
                desc_reg <= 1'b0;
                mism_reg <= 1'b0;
                chk_reg  <= 1'b0;
            end
            else
            begin
                mism_reg <= mism_reg | (chk_reg & owner_ne);
                chk_reg  <= ctl.scan_step & par_sub & lk_j;
                if (ctl.scan_step)
                begin
                    sub_reg[j_idx] <= is_t | par_sub;
                    lp_reg[j_idx]  <= lk_j | par_lp;
                    if (is_t)
                    begin
                        anc_reg <= par_lp;
                    end
                    desc_reg <= desc_reg | (par_sub & lk_j);
                    j_reg    <= j_reg + NW'(1);
                    if (j_nz)
                    begin
                        if (c_reg == m_eff)
                        begin
                            p_reg <= p_reg + IW'(1);
                            c_reg <= 5'd1;
                        end
                        else
                        begin
                            c_reg <= c_reg + 5'd1;
                        end
                    end
                end
            end
        end
    end

endmodule

[design/mtl_ctrl.sv]
`include "assert_macros.svh"

module mtl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               success,
    output mtl_pkg::ctl_cmd_t  ctl,
    input  mtl_pkg::ctl_sts_t  sts
);
    import mtl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_TAIL = 3'd3;
    localparam logic [2:0] S_URD  = 3'd4;
    localparam logic [2:0] S_UCHK = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       res_reg;
    logic       res_next;
    logic       out_valid_reg;
    logic       success_reg;
    logic       lock_ok;
    logic       upg_ok;
    logic       accept;
    logic       load_out;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign success   = success_reg;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign lock_ok = !sts.t_locked && !sts.anc_hit && !sts.desc_any;
    assign upg_ok  = !sts.t_locked && !sts.anc_hit && sts.desc_any && !sts.mism;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctl.start  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!sts.in_range)
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
                else if (sts.cmd == CMD_UNLOCK)
                begin
                    state_next = S_URD;
                end
                else if (sts.cmd == CMD_LOCK || sts.cmd == CMD_UPGRADE)
                begin
                    ctl.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (sts.cmd == CMD_LOCK)
                begin
                    res_next    = lock_ok;
                    ctl.do_lock = lock_ok;
                end
                else
                begin
                    res_next       = upg_ok;
                    ctl.do_upgrade = upg_ok;
                end
                state_next = S_DONE;
            end
            S_URD:
            begin
                state_next = S_UCHK;
            end
            S_UCHK:
            begin
                res_next      = sts.t_locked && sts.owner_eq;
                ctl.do_unlock = sts.t_locked && sts.owner_eq;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            success_reg <= res_reg;
        end
    end

    `CHK_NEXT(a_accept_leaves_idle, accept, state_reg == S_DEC, "accepted request not decoded")
    `CHK_IMPLY(a_result_from_done, $rose(out_valid_reg), $past(state_reg == S_DONE), "result without request")
    `CHK_IMPLY(a_apply_one_hot, 1'b1, $onehot0({ctl.do_lock, ctl.do_unlock, ctl.do_upgrade}), "multiple updates")

endmodule

[bench/tb_mary_tree_hierarchical_lock_unit.sv]
module tb_mary_tree_hierarchical_lock_unit;
    import mtl_pkg::*;

    // Command code that the block must reject without touching any lock.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int TREE_NODES = 256;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_CONFIG,
        OP_DRAIN
    } op_kind_t;

    typedef struct {
        op_kind_t    kind;
        logic [1:0]  command;
        logic [7:0]  node_index;
        logic [15:0] user_id;
        logic        reg_index;
        logic [8:0]  reg_data;
    } lock_op_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [7:0]  node_index;
    logic [15:0] user_id;
    logic        out_valid;
    logic        out_stall;
    logic        success;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    mary_tree_hierarchical_lock_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .node_index(node_index),
        .user_id   (user_id),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .success   (success),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the lock table and the two configuration registers.
    logic [4:0]  shadow_branch;
    logic [8:0]  shadow_count;
    logic        held[TREE_NODES];
    logic [15:0] holder[TREE_NODES];

    lock_op_t pending_ops[$];
    logic     grant_q[$];
    int       fail_count;
    int       sender_gap;
    int       receiver_gap;
    int       quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int eff_branch();
        if (shadow_branch == 5'd0)
            return 1;
        if (shadow_branch > 5'd16)
            return 16;
        return shadow_branch;
    endfunction

    function automatic int eff_count();
        return (shadow_count > TREE_NODES) ? TREE_NODES : shadow_count;
    endfunction

    // True when node d is node t or sits below it in the implicit tree.
    function automatic bit under_node(int d, int t);
        int m;
        m = eff_branch();
        while (d > t)
            d = (d - 1) / m;
        return (d == t);
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < TREE_NODES; i++)
        begin
            held[i]   = 1'b0;
            holder[i] = '0;
        end
    endfunction

    // Computes the grant for one request and applies it to the shadow table.
    function automatic logic grant_request(logic [1:0] cmd, int t, logic [15:0] user);
        int  n;
        int  m;
        int  a;
        bit  anc_locked;
        bit  desc_locked;
        bit  foreign_desc;
        n = eff_count();
        m = eff_branch();
        if (t >= n)
            return 1'b0;
        anc_locked = 0;
        a = t;
        while (a > 0)
        begin
            a = (a - 1) / m;
            if (held[a])
                anc_locked = 1;
        end
        desc_locked  = 0;
        foreign_desc = 0;
        for (int j = t + 1; j < n; j++)
        begin
            if (held[j] && under_node(j, t))
            begin
                desc_locked = 1;
                if (holder[j] != user)
                    foreign_desc = 1;
            end
        end
        case (cmd)
            CMD_LOCK:
            begin
                if (held[t] || anc_locked || desc_locked)
                    return 1'b0;
                held[t]   = 1'b1;
                holder[t] = user;
                return 1'b1;
            end
            CMD_UNLOCK:
            begin
                if (!held[t] || holder[t] != user)
                    return 1'b0;
                held[t]   = 1'b0;
                holder[t] = '0;
                return 1'b1;
            end
            CMD_UPGRADE:
            begin
                if (held[t] || anc_locked || !desc_locked || foreign_desc)
                    return 1'b0;
                for (int j = t + 1; j < n; j++)
                begin
                    if (held[j] && under_node(j, t))
                    begin
                        held[j]   = 1'b0;
                        holder[j] = '0;
                    end
                end
                held[t]   = 1'b1;
                holder[t] = user;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic add_request(logic [1:0] cmd, logic [7:0] node, logic [15:0] user);
        lock_op_t op;
        op.kind       = OP_REQUEST;
        op.command    = cmd;
        op.node_index = node;
        op.user_id    = user;
        op.reg_index  = 1'b0;
        op.reg_data   = '0;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic add_config(logic idx, logic [8:0] data);
        lock_op_t op;
        op.kind       = OP_CONFIG;
        op.command    = CMD_LOCK;
        op.node_index = '0;
        op.user_id    = '0;
        op.reg_index  = idx;
        op.reg_data   = data;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic add_drain();
        lock_op_t op;
        op = '{OP_DRAIN, CMD_LOCK, 8'd0, 16'd0, 1'b0, 9'd0};
        pending_ops.insert(pending_ops.size(), op);
    endtask

    // The request stream: a directed opening, then random phases, each with a
    // fresh tree shape. Most requests stay within the node range and use a few
    // users so that locks collide and upgrades find matching descendants.
    initial
    begin
        int n_lim;
        int node;
        int pick;
        logic [1:0]  cmd;
        logic [15:0] user;

        add_request(CMD_LOCK, 8'd0, 16'd1);
        add_request(CMD_LOCK, 8'd1, 16'd1);
        add_request(CMD_UNLOCK, 8'd0, 16'd2);
        add_request(CMD_UNLOCK, 8'd0, 16'd1);
        add_request(CMD_LOCK, 8'd3, 16'd5);
        add_request(CMD_LOCK, 8'd4, 16'd5);
        add_request(CMD_UPGRADE, 8'd0, 16'd6);
        add_request(CMD_UPGRADE, 8'd0, 16'd5);
        add_request(CMD_UPGRADE, 8'd0, 16'd5);
        add_request(CMD_UNLOCK, 8'd0, 16'd5);
        add_request(CMD_UPGRADE, 8'd0, 16'd5);
        add_request(CMD_LOCK, 8'd255, 16'hFFFF);
        add_request(CMD_LOCK, 8'd0, 16'hFFFF);
        add_request(CMD_UPGRADE, 8'd0, 16'hFFFF);
        add_request(CMD_UNUSED, 8'd1, 16'hFFFF);
        add_request(CMD_UNLOCK, 8'd0, 16'hFFFF);
        add_drain();
        add_config(CFG_COUNT, 9'd200);
        add_request(CMD_LOCK, 8'd255, 16'd1);
        add_request(CMD_LOCK, 8'd199, 16'd1);
        add_config(CFG_COUNT, 9'd0);
        add_request(CMD_LOCK, 8'd0, 16'd1);
        add_config(CFG_COUNT, 9'd1);
        add_config(CFG_BRANCH, 9'd0);
        add_request(CMD_LOCK, 8'd0, 16'd0);
        add_request(CMD_LOCK, 8'd1, 16'd0);

        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0:
                begin
                    add_config(CFG_BRANCH, 9'd0);
                    add_config(CFG_COUNT, 9'd40);
                end
                1:
                begin
                    add_config(CFG_BRANCH, 9'd16);
                    add_config(CFG_COUNT, 9'd256);
                end
                2:
                begin
                    add_config(CFG_BRANCH, 9'd31);
                    add_config(CFG_COUNT, 9'd511);
                end
                3:
                begin
                    add_config(CFG_BRANCH, 9'd1);
                    add_config(CFG_COUNT, 9'd1);
                end
                4:
                begin
                    add_config(CFG_BRANCH, 9'h1FF);
                    add_config(CFG_COUNT, 9'd30);
                end
                default:
                begin
                    add_config(CFG_BRANCH, 9'($urandom_range(1, 16)));
                    add_config(CFG_COUNT, 9'($urandom_range(2, 64)));
                end
            endcase
            if (phase == 6)
                add_drain();
            n_lim = (phase == 1 || phase == 2) ? 256 : (phase == 3 ? 1 : 40);
            if (phase >= 5)
                n_lim = 64;
            for (int k = 0; k < 140; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    cmd = CMD_LOCK;
                else if (pick < 70)
                    cmd = CMD_UNLOCK;
                else if (pick < 96)
                    cmd = CMD_UPGRADE;
                else
                    cmd = CMD_UNUSED;
                if ($urandom_range(0, 9) == 0)
                    node = $urandom_range(0, 255);
                else
                    node = $urandom_range(0, n_lim - 1);
                if ($urandom_range(0, 7) == 0)
                    user = 16'($urandom);
                else
                    user = 16'($urandom_range(1, 3));
                add_request(cmd, 8'(node), user);
            end
        end
    end

    // Driver: one transfer in flight on either channel. Configuration writes
    // and drain markers hold off until the result queue has stayed empty with
    // no transfer offered, which leaves the block idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            command      <= CMD_LOCK;
            node_index   <= '0;
            user_id      <= '0;
            cfg_valid    <= 1'b0;
            cfg_index    <= CFG_BRANCH;
            cfg_data     <= '0;
            sender_gap   = 0;
            quiet_cycles = 0;
            shadow_branch = BRANCH_RST;
            shadow_count  = COUNT_RST;
            clear_table();
        end
        else
        begin : drive_step
            lock_op_t op;
            bit       calm;
            if (in_valid && !in_stall)
                grant_q.insert(grant_q.size(), grant_request(command, node_index, user_id));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BRANCH)
                    shadow_branch = cfg_data[4:0];
                else
                    shadow_count = cfg_data;
                clear_table();
            end
            if (grant_q.size() == 0 && !(in_valid && in_stall) && !(cfg_valid && !cfg_ready)
                && !(in_valid && !in_stall) && !(cfg_valid && cfg_ready))
                quiet_cycles++;
            else
                quiet_cycles = 0;
            calm = (pending_ops.size() < 250);
            if ((!in_valid || !in_stall) && (!cfg_valid || cfg_ready))
            begin
                if (sender_gap > 0 || pending_ops.size() == 0)
                begin
                    if (sender_gap > 0)
                        sender_gap--;
                    in_valid  <= 1'b0;
                    cfg_valid <= 1'b0;
                end
                else if (pending_ops[0].kind == OP_REQUEST)
                begin
                    op = pending_ops.pop_front();
                    in_valid   <= 1'b1;
                    command    <= op.command;
                    node_index <= op.node_index;
                    user_id    <= op.user_id;
                    cfg_valid  <= 1'b0;
                    if (!calm && $urandom_range(0, 9) == 0)
                        sender_gap = $urandom_range(1, 14);
                end
                else if (quiet_cycles >= 8)
                begin
                    op = pending_ops.pop_front();
                    in_valid  <= 1'b0;
                    cfg_valid <= (op.kind == OP_CONFIG);
                    cfg_index <= op.reg_index;
                    cfg_data  <= op.reg_data;
                end
                else
                begin
                    in_valid  <= 1'b0;
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stall bursts on the result side, compared against the
    // oldest predicted grant.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            receiver_gap = 0;
            fail_count   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (grant_q.size() == 0)
                begin
                    $error("success: result transfer with no request waiting");
                    fail_count++;
                end
                else
                begin : compare_step
                    logic want;
                    want = grant_q.pop_front();
                    if (success !== want)
                    begin
                        $error("success: expected %0b, actual %0b", want, success);
                        fail_count++;
                    end
                end
            end
            if (receiver_gap > 0)
            begin
                receiver_gap--;
                out_stall <= 1'b1;
            end
            else if (pending_ops.size() >= 250 && $urandom_range(0, 7) == 0)
            begin
                receiver_gap = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        wait (pending_ops.size() == 0 && !in_valid && !cfg_valid && grant_q.size() == 0);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && grant_q.size() == 0)
            $display("mary_tree_hierarchical_lock_unit regression: pass");
        else
            $display("mary_tree_hierarchical_lock_unit regression: fail");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("mary_tree_hierarchical_lock_unit regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/mtl_pkg.sv
design/mtl_datapath.sv
design/mtl_ctrl.sv
design/mary_tree_hierarchical_lock_unit.sv
bench/tb_mary_tree_hierarchical_lock_unit.sv
